// File: hdl/bel_pkg.sv
// Shared types and constants for the breakpoint envelope lookup unit.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package bel_pkg;

  localparam int BeatW   = 32;
  localparam int ValueW  = 32;
  localparam int CountW  = 7;
  localparam int IndexW  = 6;
  localparam int RegionW = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [RegionW-1:0] REGION_INTERP = 2'd0;
  localparam logic [RegionW-1:0] REGION_FIRST  = 2'd1;
  localparam logic [RegionW-1:0] REGION_LAST   = 2'd2;

  typedef struct packed {
    logic [BeatW-1:0]         beat;
    logic signed [ValueW-1:0] value;
  } point_t;

  typedef struct packed {
    logic        start;
    logic [32:0] md;
    logic [32:0] mn;
    logic [31:0] den;
  } lerp_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [32:0] mag;
  } lerp_rsp_t;

endpackage

// File: hdl/bel_if.sv
// Valid/ready channel interfaces for the item and result beats.
// Depends on bel_pkg for the field widths.
interface bel_item_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [bel_pkg::IndexW-1:0]         point_index;
  logic [bel_pkg::BeatW-1:0]          point_beat;
  logic signed [bel_pkg::ValueW-1:0]  point_value;
  logic [bel_pkg::BeatW-1:0]          query_beat;

  modport source (output valid, cmd, point_index, point_beat, point_value, query_beat,
                  input ready);
  modport sink (input valid, cmd, point_index, point_beat, point_value, query_beat,
                output ready);
endinterface

interface bel_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [bel_pkg::ValueW-1:0]  value;
  logic [bel_pkg::RegionW-1:0]        region;

  modport source (output valid, value, region, input ready);
  modport sink (input valid, value, region, output ready);
endinterface

// File: hdl/bel_point_mem.sv
// Breakpoint table: one synchronous memory of (beat, value) entries.
// One write port and one read port with registered read data; uses bel_pkg.
module bel_point_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  bel_pkg::point_t   wdata,
  input  logic              re,
  input  logic [AddrW-1:0]  raddr,
  output bel_pkg::point_t   rdata
);

  bel_pkg::point_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bel_lerp_div.sv
// Serial unit for the interpolation step: |d| * |num| / den, truncated.
// Two partial products, low and high, then one quotient bit per cycle; uses bel_pkg.
module bel_lerp_div (
  input  logic                clk,
  input  logic                rst,
  input  bel_pkg::lerp_req_t  req,
  output bel_pkg::lerp_rsp_t  rsp
);

  localparam int ProdW = 65;
  localparam int StepW = 7;

  typedef enum logic [2:0] {S_IDLE, S_MUL_LO, S_MUL_HI, S_DIV, S_DONE} state_t;

  state_t            state;
  logic [32:0]       md;
  logic [32:0]       mn;
  logic [31:0]       den;
  logic [ProdW-1:0]  dq;
  logic [31:0]       rem;
  logic [StepW-1:0]  step;

  logic [49:0]       mul_lo;
  logic [48:0]       mul_hi;
  logic [32:0]       sh;
  logic [32:0]       diff;
  logic              take;

  assign mul_lo = 50'(md) * 50'(mn[16:0]);
  assign mul_hi = 49'(md) * 49'(mn[32:17]);
  assign sh     = {rem, dq[ProdW-1]};
  assign take   = sh >= {1'b0, den};
  assign diff   = sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            md    <= req.md;
            mn    <= req.mn;
            den   <= req.den;
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          dq    <= ProdW'(mul_lo);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          dq    <= dq + (ProdW'(mul_hi) << 17);
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= take ? diff[31:0] : sh[31:0];
          dq   <= {dq[ProdW-2:0], take};
          step <= step + StepW'(1);
          if (step == StepW'(ProdW - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (state == S_DONE);
  assign rsp.ovf  = |dq[ProdW-1:33];
  assign rsp.mag  = dq[32:0];

endmodule

// File: hdl/breakpoint_envelope_lookup_unit.sv
// Breakpoint envelope lookup: piecewise linear interpolation over a breakpoint table.
// Uses bel_pkg, bel_item_if, bel_result_if, bel_point_mem and bel_lerp_div.
//
// An item beat on the item channel either writes one breakpoint (cmd write) or
// asks for the envelope value at a beat position (cmd query). A write gives no
// result beat. A query gives exactly one beat on the result channel with the
// value and the region code. A query reads the first and the last entry; if the
// query beat lies between them, it then scans the table from entry one, one
// entry per cycle from the memory read port, until it finds the first entry at
// or beyond the query beat. An interpolated value also waits on the serial
// divider, whose partial products and quotient bits dominate its time.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, a finished query holds until that register frees.
// point_count is written through cfg_we/cfg_wdata; the user must do so only while the unit
// is idle, which the unit does not enforce. Reset sets point_count to one and empties the
// output; the table keeps its contents and an entry must be written before a query reads it.
module breakpoint_envelope_lookup_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bel_pkg::CountW-1:0]     cfg_wdata,
  bel_item_if.sink                       item,
  bel_result_if.source                   result
);

  localparam int AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW  = (AddrW + 1 > bel_pkg::CountW) ? AddrW + 1 : bel_pkg::CountW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POINTS);

  typedef enum logic [2:0] {S_IDLE, S_FIRST, S_LAST, S_SCAN, S_LERP, S_OUT} state_t;

  state_t                             state;
  logic [bel_pkg::CountW-1:0]         point_count;
  logic [bel_pkg::BeatW-1:0]          q;
  bel_pkg::point_t                    prev;
  logic [CntW-1:0]                    scan_idx;
  logic                               neg;
  logic signed [bel_pkg::ValueW-1:0]  va_keep;
  logic signed [bel_pkg::ValueW-1:0]  res_value;
  logic [bel_pkg::RegionW-1:0]        res_region;
  logic                               out_valid;
  logic signed [bel_pkg::ValueW-1:0]  out_value;
  logic [bel_pkg::RegionW-1:0]        out_region;

  logic [CntW-1:0]                    cnt_ext;
  logic [CntW-1:0]                    act_cnt;
  logic [CntW-1:0]                    last_idx;
  logic [CntW-1:0]                    scan_next;
  logic [CntW-1:0]                    wr_idx;
  logic                               accept;
  logic                               out_load;
  logic                               mem_we;
  logic                               rd_en;
  logic [AddrW-1:0]                   rd_addr;
  bel_pkg::point_t                    wdata;
  bel_pkg::point_t                    rdata;
  logic                               found;
  logic signed [32:0]                 d;
  logic signed [32:0]                 num;
  bel_pkg::lerp_req_t                 div_req;
  bel_pkg::lerp_rsp_t                 div_rsp;
  logic signed [34:0]                 sum;
  logic signed [34:0]                 mag_ext;
  logic signed [bel_pkg::ValueW-1:0]  lerp_value;

  assign cnt_ext   = CntW'(point_count);
  assign act_cnt   = (cnt_ext == '0) ? CntW'(1) : ((cnt_ext > MaxCnt) ? MaxCnt : cnt_ext);
  assign last_idx  = act_cnt - CntW'(1);
  assign scan_next = scan_idx + CntW'(1);
  assign wr_idx    = CntW'(item.point_index);

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_load   = (state == S_OUT) && (!out_valid || result.ready);
  assign mem_we     = accept && (item.cmd == bel_pkg::CMD_WRITE) && (wr_idx < MaxCnt);
  assign wdata.beat  = item.point_beat;
  assign wdata.value = item.point_value;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        rd_en = accept && (item.cmd == bel_pkg::CMD_QUERY);
      end
      S_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = last_idx[AddrW-1:0];
      end
      S_LAST: begin
        rd_en   = 1'b1;
        rd_addr = AddrW'(1);
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_next[AddrW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  bel_point_mem #(
    .Depth (MAX_POINTS),
    .AddrW (AddrW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx[AddrW-1:0]),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign found = rdata.beat >= q;
  assign d     = {rdata.value[31], rdata.value} - {prev.value[31], prev.value};
  assign num   = $signed({1'b0, q}) - $signed({1'b0, prev.beat});

  assign div_req.start = (state == S_SCAN) && found && (rdata.beat > prev.beat);
  assign div_req.md    = d[32] ? 33'(-d) : 33'(d);
  assign div_req.mn    = num[32] ? 33'(-num) : 33'(num);
  assign div_req.den   = rdata.beat - prev.beat;

  bel_lerp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign mag_ext = $signed({2'b00, div_rsp.mag});
  assign sum     = {{3{va_keep[31]}}, va_keep} + (neg ? -mag_ext : mag_ext);

  always_comb begin
    if (div_rsp.ovf) begin
      lerp_value = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
      lerp_value = sum[31:0];
    end else begin
      lerp_value = sum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= bel_pkg::CountW'(1);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && item.cmd == bel_pkg::CMD_QUERY) begin
            q     <= item.query_beat;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          prev  <= rdata;
          state <= S_LAST;
        end
        S_LAST: begin
          if (q <= prev.beat) begin
            res_value  <= prev.value;
            res_region <= bel_pkg::REGION_FIRST;
            state      <= S_OUT;
          end else if (q >= rdata.beat) begin
            res_value  <= rdata.value;
            res_region <= bel_pkg::REGION_LAST;
            state      <= S_OUT;
          end else begin
            scan_idx <= CntW'(1);
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            if (rdata.beat > prev.beat) begin
              neg     <= d[32] ^ num[32];
              va_keep <= prev.value;
              state   <= S_LERP;
            end else begin
              res_value  <= prev.value;
              res_region <= bel_pkg::REGION_INTERP;
              state      <= S_OUT;
            end
          end else begin
            prev     <= rdata;
            scan_idx <= scan_next;
          end
        end
        S_LERP: begin
          if (div_rsp.done) begin
            res_value  <= lerp_value;
            res_region <= bel_pkg::REGION_INTERP;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_value  <= res_value;
            out_region <= res_region;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid  = out_valid;
  assign result.value  = out_value;
  assign result.region = out_region;

`ifndef SYNTH
  a_done_in_lerp: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_LERP)
    else $error("divider finished outside the interpolation wait");

  a_start_to_lerp: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> state == S_LERP)
    else $error("divider start did not enter the interpolation wait");

  a_lerp_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_LERP |=> (state == S_LERP || state == S_OUT))
    else $error("interpolation wait left to a wrong state");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_OUT)
    else $error("result beat raised without a finished query");
`endif

endmodule

// File: bench/breakpoint_envelope_lookup_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for breakpoint_envelope_lookup_unit: directed table, then random phases.
// Depends on bel_pkg, bel_item_if, bel_result_if and the unit itself from hdl/.
module breakpoint_envelope_lookup_unit_tb;

  typedef struct packed {
    logic signed [bel_pkg::ValueW-1:0] value;
    logic [bel_pkg::RegionW-1:0]       region;
  } envelope_t;

  typedef enum logic [1:0] {STEP_WRITE, STEP_QUERY, STEP_COUNT} step_kind_t;

  typedef struct {
    step_kind_t                 kind;
    logic [bel_pkg::IndexW-1:0] idx;
    logic [bel_pkg::BeatW-1:0]  beat;
    logic [bel_pkg::ValueW-1:0] value;
    bit                         typed;
    envelope_t                  want;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [bel_pkg::CountW-1:0] cfg_wdata;

  bel_item_if   item_ch();
  bel_result_if result_ch();

  breakpoint_envelope_lookup_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  logic [bel_pkg::BeatW-1:0]         bp_beat [64];
  logic signed [bel_pkg::ValueW-1:0] bp_value [64];
  logic [bel_pkg::CountW-1:0]        point_count_reg;

  envelope_t pending_env[$];
  envelope_t oldest;
  step_t     steps[$];
  int        mismatches = 0;
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;
  int        rx_hold_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int active_points();
    if (point_count_reg == 0) return 1;
    if (point_count_reg > 64) return 64;
    return point_count_reg;
  endfunction

  function automatic envelope_t envelope_at(input logic [bel_pkg::BeatW-1:0] q);
    envelope_t r;
    int n;
    int last;
    logic signed [bel_pkg::ValueW-1:0] va;
    longint d;
    longint num;
    longint s;
    logic [63:0] md;
    logic [63:0] mn;
    logic [63:0] den;
    logic [63:0] mag;
    bit neg;
    n = active_points();
    last = n - 1;
    if (q <= bp_beat[0]) begin
      r.value = bp_value[0];
      r.region = bel_pkg::REGION_FIRST;
    end else if (q >= bp_beat[last]) begin
      r.value = bp_value[last];
      r.region = bel_pkg::REGION_LAST;
    end else begin
      r.region = bel_pkg::REGION_INTERP;
      r.value = bp_value[last];
      for (int i = 1; i < n; i++) begin
        if (bp_beat[i] >= q) begin
          va = bp_value[i-1];
          if (bp_beat[i] > bp_beat[i-1]) begin
            d = longint'(bp_value[i]) - longint'(va);
            num = longint'({32'b0, q}) - longint'({32'b0, bp_beat[i-1]});
            neg = (d < 0) != (num < 0);
            md = (d < 0) ? -d : d;
            mn = (num < 0) ? -num : num;
            den = {32'b0, bp_beat[i]} - {32'b0, bp_beat[i-1]};
            mag = (md * mn) / den;
            if (mag >= 64'h2_0000_0000) begin
              r.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
              s = longint'(va) + (neg ? -longint'(mag) : longint'(mag));
              if (s > 64'sh7FFF_FFFF) r.value = 32'h7FFF_FFFF;
              else if (s < -64'sh8000_0000) r.value = 32'h8000_0000;
              else r.value = s[31:0];
            end
          end else begin
            r.value = va;
          end
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [bel_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_step(input step_kind_t kind,
                                   input logic [bel_pkg::IndexW-1:0] idx,
                                   input logic [bel_pkg::BeatW-1:0] beat,
                                   input logic [bel_pkg::ValueW-1:0] value,
                                   input bit typed,
                                   input logic [bel_pkg::ValueW-1:0] want_value,
                                   input logic [bel_pkg::RegionW-1:0] want_region);
    step_t s;
    s.kind = kind;
    s.idx = idx;
    s.beat = beat;
    s.value = value;
    s.typed = typed;
    s.want.value = want_value;
    s.want.region = want_region;
    steps.insert(steps.size(), s);
  endfunction

  task automatic send_item(input logic cmd, input logic [bel_pkg::IndexW-1:0] idx,
                           input logic [bel_pkg::BeatW-1:0] pbeat,
                           input logic [bel_pkg::ValueW-1:0] pval,
                           input logic [bel_pkg::BeatW-1:0] qbeat, input bit typed,
                           input envelope_t typed_env);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap != 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.cmd = cmd;
    item_ch.point_index = idx;
    item_ch.point_beat = pbeat;
    item_ch.point_value = pval;
    item_ch.query_beat = qbeat;
    item_ch.valid = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    if (cmd == bel_pkg::CMD_WRITE) begin
      bp_beat[idx] = pbeat;
      bp_value[idx] = pval;
    end else begin
      pending_env.insert(pending_env.size(), typed ? typed_env : envelope_at(qbeat));
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_env.size() != 0 && guard < 40000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  task automatic set_point_count(input logic [bel_pkg::CountW-1:0] cnt);
    drain_results();
    repeat (16) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = cnt;
    point_count_reg = cnt;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Result side: per-beat random stall while rx_idle is set, plus one long hold-off on request.
  initial begin
    int wait_n;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        result_ch.ready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      wait_n = rx_idle ? $urandom_range(0, 10) : 0;
      if (wait_n != 0) begin
        result_ch.ready = 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_env.size() == 0) begin
        $error("result beat with no query pending: value %0d region %0d",
               result_ch.value, result_ch.region);
        mismatches++;
      end else begin
        oldest = pending_env.pop_front();
        if (result_ch.value !== oldest.value) begin
          $error("value: expected %0d, got %0d", oldest.value, result_ch.value);
          mismatches++;
        end
        if (result_ch.region !== oldest.region) begin
          $error("region: expected %0d, got %0d", oldest.region, result_ch.region);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int p;
    int k;
    int j;
    int sel;
    int scale;
    int cnt;
    int n_eff;
    logic [1:0] mode;
    logic [bel_pkg::BeatW-1:0] b;
    logic [bel_pkg::BeatW-1:0] lo;
    logic [bel_pkg::BeatW-1:0] hi;
    logic [bel_pkg::BeatW-1:0] qb;
    logic [32:0] acc;
    logic [63:0] span;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.cmd = bel_pkg::CMD_WRITE;
    item_ch.point_index = '0;
    item_ch.point_beat = '0;
    item_ch.point_value = '0;
    item_ch.query_beat = '0;
    point_count_reg = 7'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_step(STEP_WRITE, 0, 32'h0001_0000, 32'h7FFF_FFFF, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0000_0000, 0, 1, 32'h7FFF_FFFF, bel_pkg::REGION_FIRST);
    add_step(STEP_QUERY, 0, 32'h0001_0000, 0, 1, 32'h7FFF_FFFF, bel_pkg::REGION_FIRST);
    add_step(STEP_QUERY, 0, 32'hFFFF_FFFF, 0, 1, 32'h7FFF_FFFF, bel_pkg::REGION_LAST);
    add_step(STEP_WRITE, 1, 32'h0002_0000, 32'h8000_0000, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_WRITE, 2, 32'h0002_0000, 32'h0000_0000, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_WRITE, 3, 32'hFFFF_FFFF, 32'h0001_0000, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_COUNT, 0, 0, 4, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0001_0001, 0, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0001_8000, 0, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0002_0000, 0, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0003_0000, 0, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'hFFFF_FFFE, 0, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'hFFFF_FFFF, 0, 1, 32'h0001_0000, bel_pkg::REGION_LAST);
    add_step(STEP_COUNT, 0, 0, 0, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0005_0000, 0, 1, 32'h7FFF_FFFF, bel_pkg::REGION_LAST);
    add_step(STEP_WRITE, 4, 32'h0000_8000, 32'h1234_5678, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_COUNT, 0, 0, 5, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0001_0001, 0, 1, 32'h1234_5678, bel_pkg::REGION_LAST);
    add_step(STEP_QUERY, 0, 32'h0000_4000, 0, 1, 32'h7FFF_FFFF, bel_pkg::REGION_FIRST);
    add_step(STEP_WRITE, 2, 32'h0000_1000, 32'hDEAD_BEEF, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_COUNT, 0, 0, 4, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0003_0000, 0, 0, 0, bel_pkg::REGION_INTERP);
    add_step(STEP_QUERY, 0, 32'h0001_8000, 0, 0, 0, bel_pkg::REGION_INTERP);

    foreach (steps[s]) begin
      case (steps[s].kind)
        STEP_WRITE: begin
          send_item(bel_pkg::CMD_WRITE, steps[s].idx, steps[s].beat, steps[s].value,
                    32'h0, 0, '0);
        end
        STEP_QUERY: begin
          send_item(bel_pkg::CMD_QUERY, '0, 32'h0, 32'h0, steps[s].beat, steps[s].typed,
                    steps[s].want);
        end
        default: begin
          set_point_count(steps[s].value[bel_pkg::CountW-1:0]);
        end
      endcase
    end

    for (p = 0; p < 10; p++) begin
      mode = (p == 0) ? 2'b11 : (p == 1) ? 2'b00 : 2'($urandom_range(0, 3));
      tx_idle = mode[0];
      rx_idle = mode[1];

      // Rebuild the whole table in ascending beat order, with some repeated beats.
      if (p == 0 || $urandom_range(0, 2) == 0) begin
        scale = $urandom_range(0, 2);
        acc = 33'($urandom_range(0, 32'h1000_0000));
        for (j = 0; j < 64; j++) begin
          b = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
          send_item(bel_pkg::CMD_WRITE, 6'(j), b, pick_value(), $urandom, 0, '0);
          if ($urandom_range(0, 7) != 0) begin
            case (scale)
              0: acc = acc + 33'($urandom & 32'h0000_FFFF);
              1: acc = acc + 33'($urandom & 32'h00FF_FFFF);
              default: acc = acc + 33'($urandom & 32'h03FF_FFFF);
            endcase
          end
        end
      end

      case (p)
        0: cnt = 64;
        1: cnt = 127;
        2: cnt = 1;
        3: cnt = 0;
        4: cnt = 2;
        5: cnt = 65;
        default: cnt = $urandom_range(1, 64);
      endcase
      set_point_count(7'(cnt));
      if (p == 1) rx_hold_cycles = 400;

      for (k = 0; k < 100; k++) begin
        if (p == 5 && k == 50) drain_results();
        n_eff = active_points();
        if ($urandom_range(0, 4) == 0) begin
          j = $urandom_range(0, 63);
          lo = (j == 0) ? 32'h0 : bp_beat[j-1];
          hi = (j == 63) ? 32'hFFFF_FFFF : bp_beat[j+1];
          if ($urandom_range(0, 1) == 1 && lo <= hi) begin
            span = {32'b0, hi} - {32'b0, lo} + 64'd1;
            b = lo + 32'({$urandom, $urandom} % span);
          end else begin
            b = $urandom;
          end
          send_item(bel_pkg::CMD_WRITE, 6'(j), b, pick_value(), $urandom, 0, '0);
        end else begin
          sel = $urandom_range(0, 9);
          j = $urandom_range(0, n_eff - 1);
          case (sel)
            0: qb = 32'h0000_0000;
            1: qb = 32'hFFFF_FFFF;
            2: qb = $urandom;
            3, 4: qb = bp_beat[j];
            5: qb = bp_beat[j] + ($urandom_range(0, 1) == 1 ? 32'h1 : 32'hFFFF_FFFF);
            default: begin
              lo = (j == 0) ? bp_beat[0] : bp_beat[j-1];
              hi = bp_beat[j];
              if (lo < hi) begin
                span = {32'b0, hi} - {32'b0, lo} + 64'd1;
                qb = lo + 32'({32'b0, $urandom} % span);
              end else begin
                qb = $urandom;
              end
            end
          endcase
          send_item(bel_pkg::CMD_QUERY, 6'($urandom), $urandom, $urandom, qb, 0, '0);
        end
      end
    end

    drain_results();
    repeat (150) @(negedge clk);
    if (pending_env.size() != 0) begin
      $error("%0d expected results never arrived", pending_env.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
